>>> sv/swsc_pkg.sv
package swsc_pkg;

    // default build sizes
    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 20;

    // fixed field widths
    localparam int SAMPLE_W = 20;
    localparam int WLEN_W   = 11;
    localparam int THR_W    = 20;
    localparam int POS_W    = 32;
    localparam int TAG_W    = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_THRESHOLD     = 1'b1;

    // command from the top level to a deque unit
    typedef struct packed {
        logic             start;
        logic             clear;
        logic [TAG_W-1:0] seq;
    } deque_cmd_t;

    // status back from a deque unit
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] front;
    } deque_stat_t;

endpackage

>>> sv/swsc_ram.sv
module swsc_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/swsc_deque.sv
// Monotonic max deque in a ring buffer. Feed inverted values for a min deque.
module swsc_deque #(
    parameter int DEPTH = 1024,
    parameter int VAL_W = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swsc_pkg::deque_cmd_t             cmd,
    input  logic [VAL_W-1:0]                 val,
    input  logic [$clog2(DEPTH+1)-1:0]       wlen,
    output swsc_pkg::deque_stat_t            stat
);

    import swsc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int SUM_W = LEN_W + 1;
    localparam int ENT_W = TAG_W + VAL_W;

    typedef enum logic [3:0] {
        DQ_IDLE = 4'b0001,
        DQ_HEAD = 4'b0010,
        DQ_TAIL = 4'b0100,
        DQ_PUSH = 4'b1000
    } dq_state_t;

    dq_state_t        state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] front_reg, front_next;
    logic             done_reg, done_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;

    logic [TAG_W-1:0] rd_tag, age;
    logic [VAL_W-1:0] rd_val;
    logic             evict;
    logic [IDX_W-1:0] head_inc;

    // ring index head + k, k at most DEPTH
    function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] h,
                                                 input logic [LEN_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(k);
        if (s >= SUM_W'(DEPTH))
            ring_at = IDX_W'(s - SUM_W'(DEPTH));
        else
            ring_at = IDX_W'(s);
    endfunction

    swsc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_tag   = ram_rdata[VAL_W +: TAG_W];
    assign rd_val   = ram_rdata[VAL_W-1:0];
    assign age      = cmd.seq - rd_tag;
    assign evict    = age >= TAG_W'(wlen);
    assign head_inc = ring_at(head_reg, LEN_W'(1));

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        len_next   = len_reg;
        val_next   = val_reg;
        front_next = front_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = ring_at(head_reg, len_reg);
        ram_wdata  = {cmd.seq, val_reg};
        ram_raddr  = head_reg;

        unique case (state_reg)
            DQ_IDLE:
            begin
                if (cmd.clear)
                begin
                    head_next = '0;
                    len_next  = '0;
                end
                else if (cmd.start)
                begin
                    val_next = val;
                    if (len_reg == '0)
                        state_next = DQ_PUSH;
                    else
                        state_next = DQ_HEAD;
                end
            end
            DQ_HEAD:
            begin
                if (evict)
                begin
                    head_next = head_inc;
                    len_next  = len_reg - LEN_W'(1);
                    ram_raddr = head_inc;
                    if (len_reg == LEN_W'(1))
                        state_next = DQ_PUSH;
                end
                else
                begin
                    front_next = rd_val;
                    ram_raddr  = ring_at(head_reg, len_reg - LEN_W'(1));
                    state_next = DQ_TAIL;
                end
            end
            DQ_TAIL:
            begin
                // tail entry dominated by the new value
                if (rd_val <= val_reg)
                begin
                    len_next = len_reg - LEN_W'(1);
                    if (len_reg == LEN_W'(1))
                        state_next = DQ_PUSH;
                    else
                        ram_raddr = ring_at(head_reg, len_reg - LEN_W'(2));
                end
                else
                begin
                    state_next = DQ_PUSH;
                end
            end
            DQ_PUSH:
            begin
                if (len_reg < LEN_W'(DEPTH))
                begin
                    ram_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
                if (len_reg == '0)
                    front_next = val_reg;
                done_next  = 1'b1;
                state_next = DQ_IDLE;
            end
            default:
            begin
                state_next = DQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DQ_IDLE;
            head_reg  <= '0;
            len_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        front_reg <= front_next;
    end

    assign stat.done  = done_reg;
    assign stat.front = SAMPLE_W'(front_reg);

endmodule

>>> sv/sliding_window_spread_check.sv
// Channel   Direction  Handshake            Beat contents
// in        sink       in_valid / in_stall  sample, last_sample
// out       source     out_valid / out_stall start_position, none_found, last
// cfg       APB slave  psel/penable/pready  window_length (0x0), threshold (0x4)
//
// One sample beat is in flight at a time. A beat runs accept, head check, tail
// compare, push and evaluate, plus a head check per head eviction and a tail
// compare per tail pop; an empty deque skips to push; evaluate waits for both.
// Reset is asynchronous, active low; the deque RAMs are not cleared, ring
// pointers are. A stalled output holds the next evaluate once the output register
// and the pending slot are both full, and the input stays stalled until it runs.
module sliding_window_spread_check #(
    parameter int WINDOW_MAX  = swsc_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swsc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [swsc_pkg::SAMPLE_W-1:0]    sample,
    input  logic                             last_sample,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [swsc_pkg::POS_W-1:0]       start_position,
    output logic                             none_found,
    output logic                             last,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swsc_pkg::PADDR_W-1:0]     paddr,
    input  logic [swsc_pkg::PDATA_W-1:0]     pwdata,
    output logic [swsc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    import swsc_pkg::*;

    // value width kept in the deques: sample field cut to SAMPLE_BITS
    localparam int VAL_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    // configuration
    logic [WLEN_W-1:0] wl_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              cfg_wr;

    // stream state
    logic              busy_reg, fin_reg;
    logic [POS_W-1:0]  count_reg;
    logic              hit_reg;
    logic [TAG_W-1:0]  seq_reg;
    logic              got_max_reg, got_min_reg;

    // results waiting for the output register
    logic              pend_pass_reg, pend_nf_reg, pend_fin_reg;
    logic [POS_W-1:0]  pend_pos_reg;

    // output register
    logic              out_valid_reg, out_nf_reg, out_last_reg;
    logic [POS_W-1:0]  out_pos_reg;

    logic              in_take, out_load, max_done, min_done, eval;
    logic [LEN_W-1:0]  w_eff;
    logic [31:0]       wl_ext;
    logic [VAL_W-1:0]  val_in, hi, lo, spread;
    logic              pass;
    logic [POS_W-1:0]  pass_pos;

    deque_cmd_t        cmd;
    deque_stat_t       max_stat, min_stat;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= WLEN_W'(1);
            thr_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW_LENGTH: wl_reg  <= pwdata[WLEN_W-1:0];
                REG_THRESHOLD:     thr_reg <= pwdata[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_LENGTH: prdata = PDATA_W'(wl_reg);
            REG_THRESHOLD:     prdata = PDATA_W'(thr_reg);
            default:           prdata = '0;
        endcase
    end

    // window length clamped to 1..WINDOW_MAX
    assign wl_ext = 32'(wl_reg);
    assign w_eff  = (wl_reg == '0)               ? LEN_W'(1) :
                    (wl_ext > 32'(WINDOW_MAX))   ? LEN_W'(WINDOW_MAX) :
                                                   LEN_W'(wl_ext);

    // ---------------- deques ----------------
    // one beat in flight; stall while the deques work
    assign in_stall = busy_reg;
    assign in_take  = in_valid & ~busy_reg;
    assign val_in   = sample[VAL_W-1:0];

    assign cmd.start = in_take;
    assign cmd.clear = eval & fin_reg;
    assign cmd.seq   = seq_reg;

    swsc_deque #(
        .DEPTH (WINDOW_MAX),
        .VAL_W (VAL_W)
    ) u_max (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .val   (val_in),
        .wlen  (w_eff),
        .stat  (max_stat)
    );

    // min deque runs as a max deque on inverted values
    swsc_deque #(
        .DEPTH (WINDOW_MAX),
        .VAL_W (VAL_W)
    ) u_min (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .val   (~val_in),
        .wlen  (w_eff),
        .stat  (min_stat)
    );

    assign max_done = got_max_reg | max_stat.done;
    assign min_done = got_min_reg | min_stat.done;
    // evaluate once both deques are done and the result slots are free
    assign eval     = busy_reg & max_done & min_done & ~pend_pass_reg & ~pend_nf_reg;

    assign hi       = max_stat.front[VAL_W-1:0];
    assign lo       = ~min_stat.front[VAL_W-1:0];
    assign spread   = (hi >= lo) ? (hi - lo) : '0;
    assign pass     = (count_reg >= POS_W'(w_eff)) && (32'(spread) <= 32'(thr_reg));
    assign pass_pos = count_reg - POS_W'(w_eff) + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            seq_reg       <= '0;
            got_max_reg   <= 1'b0;
            got_min_reg   <= 1'b0;
            pend_pass_reg <= 1'b0;
            pend_nf_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= last_sample;
                // saturating sample count
                if (count_reg != '1)
                    count_reg <= count_reg + POS_W'(1);
            end

            // hold a done pulse until the evaluate cycle
            if (busy_reg && !eval)
            begin
                if (max_stat.done)
                    got_max_reg <= 1'b1;
                if (min_stat.done)
                    got_min_reg <= 1'b1;
            end

            if (eval)
            begin
                busy_reg      <= 1'b0;
                got_max_reg   <= 1'b0;
                got_min_reg   <= 1'b0;
                pend_pass_reg <= pass;
                pend_nf_reg   <= fin_reg & ~hit_reg & ~pass;
                if (fin_reg)
                begin
                    // end of stream: start over
                    count_reg <= '0;
                    hit_reg   <= 1'b0;
                    seq_reg   <= '0;
                end
                else
                begin
                    hit_reg <= hit_reg | pass;
                    seq_reg <= seq_reg + TAG_W'(1);
                end
            end
            else if (out_load)
            begin
                if (pend_pass_reg)
                    pend_pass_reg <= 1'b0;
                else
                    pend_nf_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            pend_pos_reg <= pass_pos;
            pend_fin_reg <= fin_reg;
        end
    end

    // ---------------- output register ----------------
    // pending results never load in the evaluate cycle (eval needs empty slots)
    assign out_load = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= pend_pass_reg | pend_nf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (pend_pass_reg)
            begin
                out_pos_reg  <= pend_pos_reg;
                out_nf_reg   <= 1'b0;
                out_last_reg <= pend_fin_reg;
            end
            else
            begin
                out_pos_reg  <= '0;
                out_nf_reg   <= 1'b1;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign start_position = out_pos_reg;
    assign none_found     = out_nf_reg;
    assign last           = out_last_reg;

endmodule

>>> sv/swsc_check.sv
module swsc_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [swsc_pkg::SAMPLE_W-1:0] sample,
    input  logic                          last_sample,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [swsc_pkg::POS_W-1:0]    start_position,
    input  logic                          none_found,
    input  logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [swsc_pkg::PDATA_W-1:0]  pwdata,
    input  logic [swsc_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready
);

    import swsc_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(start_position)
                                   && $stable(none_found) && $stable(last))
        else $error("result beat changed under stall");

    // one sample in flight: an accepted beat stalls the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // none-found beat carries position zero and ends the beat group
    a_nf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_found |-> last && (start_position == '0))
        else $error("malformed none-found beat");

    // threshold write reads back
    a_thr_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)
        |=> !(paddr[2] == REG_THRESHOLD) || (psel && penable && pwrite)
            || (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])))
        else $error("threshold readback mismatch");

endmodule

bind sliding_window_spread_check swsc_check u_swsc_check (.*);
